### hw/rtl/weighted_lsq_multilateration_2d_macros.svh
// Assertion macros for the multilateration RTL.
`ifndef WEIGHTED_LSQ_MULTILATERATION_2D_MACROS_SVH
`define WEIGHTED_LSQ_MULTILATERATION_2D_MACROS_SVH

// Same-cycle implication.
`define WLM_ASSERT_IMP(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WLM_ASSERT_NXT(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/wlm_pkg.sv
// Types, constants and micro-op tables for the multilateration block.
package wlm_pkg;

  localparam int MAX_BEACONS = 16;
  localparam int MIN_BEACONS = 3;
  localparam int CNT_W       = 6;
  localparam int DIV_Q_W     = 17;
  localparam int ITEM_LEN    = 14;
  localparam int NUM_PAIRS   = 6;
  localparam int PAIR_LEN    = 5;
  localparam logic [14:0] MIN_DIST_RESET = 15'd100;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FEW  = 2'd1;
  localparam logic [1:0] STATUS_SING = 2'd2;
  localparam logic [1:0] STATUS_MANY = 2'd3;

  typedef enum logic [3:0] {
    MOP_NONE, MOP_D0SQ, MOP_DISQ, MOP_XSQ, MOP_X0SQ, MOP_YSQ, MOP_Y0SQ,
    MOP_WAX, MOP_WAY, MOP_S0, MOP_S1, MOP_S2, MOP_S3, MOP_S4, MOP_PART
  } mop_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_BSET, WB_BADD, WB_BSUB, WB_WAX, WB_WAY, WB_SUM,
    WB_PSET, WB_PADD32, WB_PADD64, WB_FIN
  } wb_t;

  typedef enum logic [1:0] {WD_DET, WD_NX, WD_NY} wdest_t;
  typedef enum logic [1:0] {DV_W, DV_X, DV_Y} div_dst_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_DIV, S_DFIN, S_ITEM, S_POST, S_SOLVE, S_SDRAIN,
    S_CHKDET, S_STARTY, S_EMIT
  } state_t;

  typedef struct packed {
    mop_t       mop;
    wb_t        wb;
    logic [2:0] sa;
    logic [2:0] sb;
    logic [1:0] part;
    wdest_t     dest;
    logic       sub;
    logic       first;
  } uop_t;

  typedef struct packed {
    logic       accept;
    logic       ref_load;
    logic       count_bump;
    logic       count_sat;
    logic       clear_run;
    uop_t       uop;
    logic       div_start;
    logic       div_step;
    logic       div_fin;
    div_dst_t   div_sel;
    logic       emit;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             last;
    logic             det_zero;
  } sts_t;

  function automatic uop_t uop_nop();
    uop_t u;
    u = '0;
    u.mop  = MOP_NONE;
    u.wb   = WB_NONE;
    u.dest = WD_DET;
    return u;
  endfunction

  function automatic uop_t item_uop(input logic [4:0] idx);
    uop_t u;
    u = uop_nop();
    case (idx)
      5'd0: begin u.mop = MOP_WAX;  u.wb = WB_WAX;  end
      5'd1: begin u.mop = MOP_WAY;  u.wb = WB_WAY;  end
      5'd2: begin u.mop = MOP_D0SQ; u.wb = WB_BSET; end
      5'd3: begin u.mop = MOP_DISQ; u.wb = WB_BSUB; end
      5'd4: begin u.mop = MOP_XSQ;  u.wb = WB_BADD; end
      5'd5: begin u.mop = MOP_X0SQ; u.wb = WB_BSUB; end
      5'd6: begin u.mop = MOP_YSQ;  u.wb = WB_BADD; end
      5'd7: begin u.mop = MOP_Y0SQ; u.wb = WB_BSUB; end
      5'd8: begin u.mop = MOP_S0; u.wb = WB_SUM; u.sa = 3'd0; end
      5'd9: begin u.mop = MOP_S1; u.wb = WB_SUM; u.sa = 3'd1; end
      5'd10: begin u.mop = MOP_S2; u.wb = WB_SUM; u.sa = 3'd2; end
      5'd11: begin u.mop = MOP_S3; u.wb = WB_SUM; u.sa = 3'd3; end
      5'd12: begin u.mop = MOP_S4; u.wb = WB_SUM; u.sa = 3'd4; end
      default: u = uop_nop();
    endcase
    return u;
  endfunction

  function automatic uop_t solve_uop(input logic [2:0] pair, input logic [2:0] j);
    uop_t u;
    u = uop_nop();
    case (pair)
      3'd0: begin u.sa = 3'd0; u.sb = 3'd2; u.dest = WD_DET; u.first = 1'b1; end
      3'd1: begin u.sa = 3'd1; u.sb = 3'd1; u.dest = WD_DET; u.sub = 1'b1; end
      3'd2: begin u.sa = 3'd2; u.sb = 3'd3; u.dest = WD_NX; u.first = 1'b1; end
      3'd3: begin u.sa = 3'd1; u.sb = 3'd4; u.dest = WD_NX; u.sub = 1'b1; end
      3'd4: begin u.sa = 3'd0; u.sb = 3'd4; u.dest = WD_NY; u.first = 1'b1; end
      3'd5: begin u.sa = 3'd1; u.sb = 3'd3; u.dest = WD_NY; u.sub = 1'b1; end
      default: u = uop_nop();
    endcase
    case (j)
      3'd0: begin u.mop = MOP_PART; u.part = 2'd0; u.wb = WB_PSET;   end
      3'd1: begin u.mop = MOP_PART; u.part = 2'd1; u.wb = WB_PADD32; end
      3'd2: begin u.mop = MOP_PART; u.part = 2'd2; u.wb = WB_PADD32; end
      3'd3: begin u.mop = MOP_PART; u.part = 2'd3; u.wb = WB_PADD64; end
      3'd4: begin u.mop = MOP_NONE; u.wb = WB_FIN; end
      default: begin u.mop = MOP_NONE; u.wb = WB_NONE; end
    endcase
    return u;
  endfunction

endpackage

### hw/rtl/wlm_ctrl.sv
// Sequencer for item accumulation, normal-equation solve and division.
`include "weighted_lsq_multilateration_2d_macros.svh"
module wlm_ctrl import wlm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic [4:0] step, step_next;
  logic [2:0] pair, pair_next;
  div_dst_t   dst, dst_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      pair  <= '0;
      dst   <= DV_W;
    end else begin
      state <= state_next;
      step  <= step_next;
      pair  <= pair_next;
      dst   <= dst_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    pair_next  = pair;
    dst_next   = dst;
    cmd        = '0;
    cmd.uop    = uop_nop();
    cmd.div_sel = dst;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.count == '0) begin
          cmd.ref_load = 1'b1;
          state_next   = S_POST;
        end else if (sts.count < CNT_W'(MAX_BEACONS)) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DV_W;
          dst_next      = DV_W;
          step_next     = '0;
          state_next    = S_DIV;
        end else begin
          cmd.count_sat = 1'b1;
          state_next    = S_POST;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == 5'(DIV_Q_W - 1)) begin
          step_next  = '0;
          state_next = S_DFIN;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        case (dst)
          DV_W: begin
            step_next  = '0;
            state_next = S_ITEM;
          end
          DV_X:    state_next = S_STARTY;
          DV_Y:    state_next = S_EMIT;
          default: state_next = S_IDLE;
        endcase
      end
      S_ITEM: begin
        cmd.uop = item_uop(step);
        if (step == 5'(ITEM_LEN - 1)) begin
          cmd.count_bump = 1'b1;
          step_next      = '0;
          state_next     = S_POST;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_POST: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (sts.count > CNT_W'(MAX_BEACONS)) begin
          cmd.emit      = 1'b1;
          cmd.status    = STATUS_MANY;
          cmd.clear_run = 1'b1;
          state_next    = S_IDLE;
        end else if (sts.count < CNT_W'(MIN_BEACONS)) begin
          cmd.emit      = 1'b1;
          cmd.status    = STATUS_FEW;
          cmd.clear_run = 1'b1;
          state_next    = S_IDLE;
        end else begin
          step_next  = '0;
          pair_next  = '0;
          state_next = S_SOLVE;
        end
      end
      S_SOLVE: begin
        cmd.uop = solve_uop(pair, step[2:0]);
        if (step == 5'(PAIR_LEN - 1)) begin
          step_next = '0;
          if (pair == 3'(NUM_PAIRS - 1)) begin
            state_next = S_SDRAIN;
          end else begin
            pair_next = pair + 3'd1;
          end
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_SDRAIN: state_next = S_CHKDET;
      S_CHKDET: begin
        if (sts.det_zero) begin
          cmd.emit      = 1'b1;
          cmd.status    = STATUS_SING;
          cmd.clear_run = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DV_X;
          dst_next      = DV_X;
          step_next     = '0;
          state_next    = S_DIV;
        end
      end
      S_STARTY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DV_Y;
        dst_next      = DV_Y;
        step_next     = '0;
        state_next    = S_DIV;
      end
      S_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.status    = STATUS_OK;
        cmd.clear_run = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `WLM_ASSERT_IMP(a_accept_idle, clk, rst, cmd.accept, state == S_IDLE, "transfer outside idle")
  `WLM_ASSERT_NXT(a_emit_idle, clk, rst, cmd.emit, state == S_IDLE, "no return to idle after result")
  `WLM_ASSERT_IMP(a_emit_clears, clk, rst, cmd.emit, cmd.clear_run, "result without run clear")
  `WLM_ASSERT_IMP(a_ok_after_div, clk, rst, cmd.emit && cmd.status == STATUS_OK,
                  $past(state) == S_DFIN && $past(dst) == DV_Y, "ok result without solve")

endmodule

### hw/rtl/wlm_dp.sv
// Datapath: item registers, shared multiplier, normal sums, wide solve and divider.
module wlm_dp import wlm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic        [14:0] distance_mm,
  input  logic signed [14:0] beacon_x,
  input  logic signed [14:0] beacon_y,
  input  logic               last,
  input  logic               cfg_we,
  input  logic        [14:0] cfg_data,
  output logic               done,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic        [1:0]  status
);

  localparam logic signed [64:0] SAT_HI = {2'b00, {63{1'b1}}};
  localparam logic signed [64:0] SAT_LO = -SAT_HI;

  logic        [14:0] min_dist;
  logic        [14:0] d_in, ref_d;
  logic signed [14:0] x_in, y_in, ref_x, ref_y;
  logic               last_in;
  logic signed [16:0] ax, ay;
  logic signed [15:0] dx, dy;
  logic [CNT_W-1:0]   count;
  logic        [16:0] w;
  logic signed [33:0] bval, wax, way;
  logic signed [63:0] s0, s1, s2, s3, s4;
  logic signed [63:0] sel_a, sel_b, sel_w;
  logic        [63:0] mag_a, mag_b;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [63:0] prod64;
  logic signed [63:0] sum_new;
  uop_t               uop_q;
  logic       [127:0] pacc, fin_val;
  logic               psign;
  logic signed [127:0] det, nx, ny;
  logic       [127:0] div_num, div_den, nmag, dmag;
  logic       [127:0] dnum, dden;
  logic       [144:0] dd;
  logic        [16:0] dq;
  logic               dneg, dsat, rnd;
  logic        [17:0] qv;
  logic signed [15:0] qres, px, py;
  logic        [14:0] mclamp, mfloor;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] u;
    u = v;
    return v[63] ? (~u + 64'd1) : u;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > SAT_HI) return SAT_HI[63:0];
    if (s < SAT_LO) return SAT_LO[63:0];
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] pick(input logic [2:0] i,
      input logic signed [63:0] v0, input logic signed [63:0] v1,
      input logic signed [63:0] v2, input logic signed [63:0] v3,
      input logic signed [63:0] v4);
    logic signed [63:0] r;
    case (i)
      3'd0: r = v0;
      3'd1: r = v1;
      3'd2: r = v2;
      3'd3: r = v3;
      3'd4: r = v4;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= MIN_DIST_RESET;
    end else if (cfg_we) begin
      min_dist <= cfg_data;
    end
  end

  assign dx = $signed({beacon_x[14], beacon_x}) - $signed({ref_x[14], ref_x});
  assign dy = $signed({beacon_y[14], beacon_y}) - $signed({ref_y[14], ref_y});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      d_in    <= distance_mm;
      x_in    <= beacon_x;
      y_in    <= beacon_y;
      last_in <= last;
      ax      <= {dx, 1'b0};
      ay      <= {dy, 1'b0};
    end
    if (cmd.ref_load) begin
      ref_d <= d_in;
      ref_x <= x_in;
      ref_y <= y_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      count <= '0;
    end else if (cmd.ref_load) begin
      count <= CNT_W'(1);
    end else if (cmd.count_bump) begin
      count <= count + CNT_W'(1);
    end else if (cmd.count_sat) begin
      count <= CNT_W'(MAX_BEACONS + 1);
    end
  end

  assign sel_a = pick(cmd.uop.sa, s0, s1, s2, s3, s4);
  assign sel_b = pick(cmd.uop.sb, s0, s1, s2, s3, s4);
  assign sel_w = pick(uop_q.sa, s0, s1, s2, s3, s4);
  assign mag_a = mag64(sel_a);
  assign mag_b = mag64(sel_b);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.uop.mop)
      MOP_D0SQ: begin ma = $signed({19'b0, ref_d}); mb = $signed({19'b0, ref_d}); end
      MOP_DISQ: begin ma = $signed({19'b0, d_in});  mb = $signed({19'b0, d_in});  end
      MOP_XSQ: begin
        ma = $signed({{19{x_in[14]}}, x_in}); mb = ma;
      end
      MOP_X0SQ: begin
        ma = $signed({{19{ref_x[14]}}, ref_x}); mb = ma;
      end
      MOP_YSQ: begin
        ma = $signed({{19{y_in[14]}}, y_in}); mb = ma;
      end
      MOP_Y0SQ: begin
        ma = $signed({{19{ref_y[14]}}, ref_y}); mb = ma;
      end
      MOP_WAX: begin ma = $signed({17'b0, w}); mb = $signed({{17{ax[16]}}, ax}); end
      MOP_WAY: begin ma = $signed({17'b0, w}); mb = $signed({{17{ay[16]}}, ay}); end
      MOP_S0: begin ma = wax; mb = $signed({{17{ax[16]}}, ax}); end
      MOP_S1: begin ma = wax; mb = $signed({{17{ay[16]}}, ay}); end
      MOP_S2: begin ma = way; mb = $signed({{17{ay[16]}}, ay}); end
      MOP_S3: begin ma = wax; mb = bval; end
      MOP_S4: begin ma = way; mb = bval; end
      MOP_PART: begin
        ma = $signed({2'b00, cmd.uop.part[1] ? mag_a[63:32] : mag_a[31:0]});
        mb = $signed({2'b00, cmd.uop.part[0] ? mag_b[63:32] : mag_b[31:0]});
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (cmd.uop.mop == MOP_PART) begin
      psign <= sel_a[63] ^ sel_b[63];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uop_q <= uop_nop();
    end else begin
      uop_q <= cmd.uop;
    end
  end

  assign prod64  = prod[63:0];
  assign sum_new = sat_add(sel_w, prod64);
  assign fin_val = (psign ^ uop_q.sub) ? (~pacc + 128'd1) : pacc;

  always_ff @(posedge clk) begin
    case (uop_q.wb)
      WB_BSET:   bval <= prod[33:0];
      WB_BADD:   bval <= bval + prod[33:0];
      WB_BSUB:   bval <= bval - prod[33:0];
      WB_WAX:    wax  <= prod[33:0];
      WB_WAY:    way  <= prod[33:0];
      WB_PSET:   pacc <= {64'b0, prod[63:0]};
      WB_PADD32: pacc <= pacc + {32'b0, prod[63:0], 32'b0};
      WB_PADD64: pacc <= pacc + {prod[63:0], 64'b0};
      WB_FIN: begin
        case (uop_q.dest)
          WD_DET:  det <= uop_q.first ? $signed(fin_val) : det + $signed(fin_val);
          WD_NX:   nx  <= uop_q.first ? $signed(fin_val) : nx + $signed(fin_val);
          WD_NY:   ny  <= uop_q.first ? $signed(fin_val) : ny + $signed(fin_val);
          default: det <= det;
        endcase
      end
      default: bval <= bval;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      s0 <= '0;
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else if (uop_q.wb == WB_SUM) begin
      case (uop_q.sa)
        3'd0: s0 <= sum_new;
        3'd1: s1 <= sum_new;
        3'd2: s2 <= sum_new;
        3'd3: s3 <= sum_new;
        3'd4: s4 <= sum_new;
        default: s0 <= s0;
      endcase
    end
  end

  assign mfloor = (min_dist == '0) ? 15'd1 : min_dist;
  assign mclamp = (d_in > mfloor) ? d_in : mfloor;

  always_comb begin
    case (cmd.div_sel)
      DV_X: begin div_num = nx; div_den = det; end
      DV_Y: begin div_num = ny; div_den = det; end
      default: begin div_num = 128'd65536; div_den = {113'b0, mclamp}; end
    endcase
    nmag = div_num[127] ? (~div_num + 128'd1) : div_num;
    dmag = div_den[127] ? (~div_den + 128'd1) : div_den;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dnum <= nmag;
      dden <= dmag;
      dd   <= {1'b0, dmag, 16'b0};
      dq   <= '0;
      dneg <= div_num[127] ^ div_den[127];
      dsat <= ({17'b0, nmag} >= {dmag, 17'b0});
    end else if (cmd.div_step) begin
      if ({17'b0, dnum} >= dd) begin
        dnum <= dnum - dd[127:0];
        dq   <= {dq[15:0], 1'b1};
      end else begin
        dq   <= {dq[15:0], 1'b0};
      end
      dd <= dd >> 1;
    end
  end

  assign rnd = ({dnum, 1'b0} >= {1'b0, dden});

  always_comb begin
    qv = dsat ? 18'h20000 : ({1'b0, dq} + {17'b0, rnd});
    if (dneg) begin
      qres = (qv > 18'd32768) ? 16'sh8000 : $signed(~qv[15:0] + 16'd1);
    end else begin
      qres = (qv > 18'd32767) ? 16'sh7FFF : $signed(qv[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_fin) begin
      case (cmd.div_sel)
        DV_X:    px <= qres;
        DV_Y:    py <= qres;
        default: w  <= dq;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      status <= cmd.status;
      pos_x  <= (cmd.status == STATUS_OK) ? px : '0;
      pos_y  <= (cmd.status == STATUS_OK) ? py : '0;
    end
  end

  assign sts.count    = count;
  assign sts.last     = last_in;
  assign sts.det_zero = (det == '0);

endmodule

### hw/rtl/weighted_lsq_multilateration_2d.sv
// Top level: weighted least-squares 2D multilateration over a run of beacons.
// An accumulated beacon passes through the bit-serial weight divider and then the
// shared 34x34 multiplier sequence before busy falls. A reference or overflow beacon
// skips both; a last beacon of a run of 3 to 16 beacons then adds the solve (24 wide
// partial products, then two 17-step divisions unless the determinant is zero).
// One item at a time; done pulses for one cycle and cannot be stalled.
// Synchronous active-high rst clears the run state and sets the clamp to 100 mm.
module weighted_lsq_multilateration_2d import wlm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic        [14:0] distance_mm,
  input  logic signed [14:0] beacon_x,
  input  logic signed [14:0] beacon_y,
  input  logic               last,
  input  logic               cfg_we,
  input  logic        [14:0] cfg_data,
  output logic               done,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic        [1:0]  status
);

  cmd_t cmd;
  sts_t sts;

  wlm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  wlm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .distance_mm (distance_mm),
    .beacon_x    (beacon_x),
    .beacon_y    (beacon_y),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .status      (status)
  );

endmodule
